>>> rtl/core/pfe_pkg.sv
package pfe_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int NUM_VARIABLES   = 32;
   localparam int VAR_WORD_W      = 32;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_VARS = 2'd0;

   localparam logic [1:0] KIND_VAR   = 2'd0;
   localparam logic [1:0] KIND_CONST = 2'd1;
   localparam logic [1:0] KIND_NEG   = 2'd2;
   localparam logic [1:0] KIND_BIN   = 2'd3;

   localparam logic [2:0] OP_AND   = 3'd0;
   localparam logic [2:0] OP_OR    = 3'd1;
   localparam logic [2:0] OP_NIMPT = 3'd2;
   localparam logic [2:0] OP_TIMPN = 3'd3;
   localparam logic [2:0] OP_EQV   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_DEPTH = 2'd2;
   localparam logic [1:0] ST_OVER  = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] code;
      logic       push_bit;
      logic       last;
   } token_type;

   typedef struct packed {
      logic       value;
      logic [1:0] status;
   } result_type;

   function automatic logic apply_op(logic [2:0] code, logic top, logic nxt);
      logic r;
      unique case (code)
         OP_AND:   r = top & nxt;
         OP_OR:    r = top | nxt;
         OP_NIMPT: r = ~nxt | top;
         OP_TIMPN: r = ~top | nxt;
         OP_EQV:   r = ~(top ^ nxt);
         default:  r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/postfix_boolean_evaluator_unit.sv
// channel | handshake           | payload
// req     | req_valid/req_ready | token_kind, operator_code, variable_index,
//         |                     | constant_value, last_token
// rsp     | rsp_valid/rsp_ready | result_value, status
// csr     | APB write/read      | variable_values at byte address 0
//
// One item per cycle while the result register has room; rsp_valid rises after a last item is accepted:
// the item goes through the input register, and the stack updates as the result register loads.
// The stack is a shift register, so each push or pop is a single shift.
// Reset is synchronous and clears counters, error and valids; no clearing pass is needed.
// A stalled rsp holds only last items: other items keep flowing past a full result register.
module postfix_boolean_evaluator_unit #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_token_kind,
   input  logic [2:0]                     req_operator_code,
   input  logic [4:0]                     req_variable_index,
   input  logic                           req_constant_value,
   input  logic                           req_last_token,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_value,
   output logic [1:0]                     rsp_status,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam logic [6:0] NUM_VARS = 7'(pfe_pkg::NUM_VARIABLES);

   logic [pfe_pkg::VAR_WORD_W-1:0] var_values;

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           kind_ff;
   logic [2:0]           code_ff;
   logic [4:0]           idx_ff;
   logic                 cval_ff;
   logic                 last_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   pfe_pkg::result_type  rsp_ff, rsp_in;

   pfe_pkg::token_type   tok;
   pfe_pkg::result_type  result;
   logic                 out_free;
   logic                 go;
   logic                 var_bit;

   pfe_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .var_values (var_values)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // A last item needs room in the result register; others never wait.
   assign go        = s1_valid_ff && (!last_ff || out_free);
   assign req_ready = !s1_valid_ff || go;

   assign var_bit = ({2'b00, idx_ff} < NUM_VARS) ? var_values[idx_ff] : 1'b0;

   always_comb begin
      tok.kind     = kind_ff;
      tok.code     = code_ff;
      tok.push_bit = (kind_ff == pfe_pkg::KIND_VAR) ? var_bit : cval_ff;
      tok.last     = last_ff;
   end

   pfe_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .tok    (tok),
      .result (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (go && last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_token_kind;
         code_ff <= req_operator_code;
         idx_ff  <= req_variable_index;
         cval_ff <= req_constant_value;
         last_ff <= req_last_token;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.value;
   assign rsp_status       = rsp_ff.status;

   a_stall_only_last: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !go |-> last_ff && rsp_valid_ff && !rsp_ready)
      else $error("input item held without a blocked result");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_valid_ff) && rsp_valid_ff |-> $past(go && last_ff))
      else $error("result raised without a last item");

endmodule

>>> rtl/core/pfe_csr.sv
module pfe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [pfe_pkg::VAR_WORD_W-1:0]     var_values
);

   logic [pfe_pkg::VAR_WORD_W-1:0] vars_ff;
   logic [pfe_pkg::VAR_WORD_W-1:0] vars_in;
   logic                           wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == pfe_pkg::CSR_ADDR_VARS);

   always_comb begin
      vars_in = vars_ff;
      if (wr_en) begin
         vars_in = pwdata[pfe_pkg::VAR_WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_ff <= '0;
      end else begin
         vars_ff <= vars_in;
      end
   end

   assign prdata     = (paddr == pfe_pkg::CSR_ADDR_VARS) ? vars_ff : '0;
   assign var_values = vars_ff;

endmodule

>>> rtl/core/pfe_stack.sv
module pfe_stack #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  pfe_pkg::token_type     tok,
   output pfe_pkg::result_type    result
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(STACK_DEPTH);

   logic [STACK_DEPTH-1:0] stack_ff, stack_in, stack_nx;
   logic [DEPTH_W-1:0]     depth_ff, depth_in, depth_nx;
   logic [1:0]             err_ff, err_in, err_nx;

   // Top of stack sits at bit 0; pushes shift toward the bottom.
   always_comb begin
      stack_nx = stack_ff;
      depth_nx = depth_ff;
      err_nx   = err_ff;
      if (go && (err_ff == pfe_pkg::ST_OK)) begin
         unique case (tok.kind)
            pfe_pkg::KIND_VAR, pfe_pkg::KIND_CONST: begin
               if (depth_ff == FULL) begin
                  err_nx = pfe_pkg::ST_OVER;
               end else begin
                  stack_nx = {stack_ff[STACK_DEPTH-2:0], tok.push_bit};
                  depth_nx = depth_ff + 1'b1;
               end
            end
            pfe_pkg::KIND_NEG: begin
               if (depth_ff == '0) begin
                  err_nx = pfe_pkg::ST_UNDER;
               end else begin
                  stack_nx[0] = ~stack_ff[0];
               end
            end
            pfe_pkg::KIND_BIN: begin
               if (depth_ff < DEPTH_W'(2)) begin
                  err_nx = pfe_pkg::ST_UNDER;
               end else begin
                  // Pop two, push one: shift up by one and replace the top.
                  stack_nx    = stack_ff >> 1;
                  stack_nx[0] = pfe_pkg::apply_op(tok.code, stack_ff[0], stack_ff[1]);
                  depth_nx    = depth_ff - 1'b1;
               end
            end
            default: begin
               stack_nx = stack_ff;
            end
         endcase
      end
   end

   always_comb begin
      result.value  = 1'b0;
      result.status = err_nx;
      if (err_nx == pfe_pkg::ST_OK) begin
         if (depth_nx != DEPTH_W'(1)) begin
            result.status = pfe_pkg::ST_DEPTH;
         end else begin
            result.value = stack_nx[0];
         end
      end
   end

   always_comb begin
      stack_in = stack_nx;
      depth_in = depth_nx;
      err_in   = err_nx;
      if (go && tok.last) begin
         depth_in = '0;
         err_in   = pfe_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= pfe_pkg::ST_OK;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= FULL)
      else $error("stack depth beyond capacity");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      go && tok.last |=> (depth_ff == '0) && (err_ff == pfe_pkg::ST_OK))
      else $error("stack not cleared after last item");

   a_err_freezes: assert property (@(posedge clock) disable iff (reset)
      go && !tok.last && (err_ff != pfe_pkg::ST_OK) |=> $stable(depth_ff) && $stable(err_ff))
      else $error("stack moved while an error was pending");

endmodule

>>> test/postfix_result_checker.sv
module postfix_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_token_kind,
   input  logic [2:0]                     req_operator_code,
   input  logic [4:0]                     req_variable_index,
   input  logic                           req_constant_value,
   input  logic                           req_last_token,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_result_value,
   input  logic [1:0]                     rsp_status,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             failures,
   output int                             pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_MAX = pfe_pkg::STACK_DEPTH_DEF;

   logic [FILL_MAX-1:0]            stack_bits;
   int                             stack_fill;
   logic [1:0]                     sticky_err;
   logic [pfe_pkg::VAR_WORD_W-1:0] var_word;
   pfe_pkg::result_type            expected_results[$];

   function automatic logic combine_truth(logic [2:0] code, logic top, logic nxt);
      case (code)
         pfe_pkg::OP_AND:   return top & nxt;
         pfe_pkg::OP_OR:    return top | nxt;
         pfe_pkg::OP_NIMPT: return top | !nxt;
         pfe_pkg::OP_TIMPN: return nxt | !top;
         pfe_pkg::OP_EQV:   return top == nxt;
         default:           return 1'b0;
      endcase
   endfunction

   task automatic push_truth(input logic b);
      if (stack_fill >= FILL_MAX) begin
         sticky_err = pfe_pkg::ST_OVER;
      end else begin
         stack_bits[stack_fill] = b;
         stack_fill++;
      end
   endtask

   task automatic eval_token();
      logic                top;
      logic                nxt;
      pfe_pkg::result_type res;
      // once an error is latched, the stack is frozen until the last token
      if (sticky_err == pfe_pkg::ST_OK) begin
         case (req_token_kind)
            pfe_pkg::KIND_VAR: begin
               push_truth((req_variable_index < pfe_pkg::NUM_VARIABLES) ?
                          var_word[req_variable_index] : 1'b0);
            end
            pfe_pkg::KIND_CONST: begin
               push_truth(req_constant_value);
            end
            pfe_pkg::KIND_NEG: begin
               if (stack_fill < 1) sticky_err = pfe_pkg::ST_UNDER;
               else stack_bits[stack_fill-1] = ~stack_bits[stack_fill-1];
            end
            default: begin
               if (stack_fill < 2) begin
                  sticky_err = pfe_pkg::ST_UNDER;
               end else begin
                  top = stack_bits[stack_fill-1];
                  nxt = stack_bits[stack_fill-2];
                  stack_fill -= 2;
                  push_truth(combine_truth(req_operator_code, top, nxt));
               end
            end
         endcase
      end
      if (req_last_token) begin
         res.value  = 1'b0;
         res.status = sticky_err;
         if (sticky_err == pfe_pkg::ST_OK) begin
            if (stack_fill != 1) res.status = pfe_pkg::ST_DEPTH;
            else res.value = stack_bits[0];
         end
         expected_results.insert(expected_results.size(), res);
         stack_bits = '0;
         stack_fill = 0;
         sticky_err = pfe_pkg::ST_OK;
      end
   endtask

   always @(posedge clock) begin
      pfe_pkg::result_type want;
      if (reset) begin
         stack_bits = '0;
         stack_fill = 0;
         sticky_err = pfe_pkg::ST_OK;
         var_word   = '0;
         expected_results.delete();
         failures   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (failures < 10)
                  $display("unexpected item: value %0d status %0d",
                           rsp_result_value, rsp_status);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (want.value !== rsp_result_value) begin
                  if (failures < 10)
                     $display("value mismatch: expected %0d got %0d",
                              want.value, rsp_result_value);
                  failures++;
               end
               if (want.status !== rsp_status) begin
                  if (failures < 10)
                     $display("status mismatch: expected %0d got %0d",
                              want.status, rsp_status);
                  failures++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == pfe_pkg::CSR_ADDR_VARS)
            var_word = pwdata;
         if (req_valid && req_ready)
            eval_token();
      end
      pending_results = expected_results.size();
   end

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0] kind;
      logic [2:0] code;
      logic [4:0] idx;
      logic       cval;
      logic       last;
   } pf_token_type;

   localparam int ITEM_TOTAL  = 1300;
   localparam int PHASE_COUNT = 6;
   // operator code with no defined operation
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [1:0]                     req_token_kind = '0;
   logic [2:0]                     req_operator_code = '0;
   logic [4:0]                     req_variable_index = '0;
   logic                           req_constant_value = 1'b0;
   logic                           req_last_token = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_result_value;
   logic [1:0]                     rsp_status;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [pfe_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [pfe_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [pfe_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;
   int                             failures;
   int                             pending_results;
   int                             items_sent = 0;
   bit                             req_burst = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   postfix_boolean_evaluator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_token_kind(req_token_kind), .req_operator_code(req_operator_code),
      .req_variable_index(req_variable_index), .req_constant_value(req_constant_value),
      .req_last_token(req_last_token),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   postfix_result_checker result_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_token_kind(req_token_kind), .req_operator_code(req_operator_code),
      .req_variable_index(req_variable_index), .req_constant_value(req_constant_value),
      .req_last_token(req_last_token),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .failures(failures), .pending_results(pending_results)
   );

   function automatic pf_token_type make_token(logic [1:0] kind);
      pf_token_type t;
      t.kind = kind;
      t.code = 3'($urandom_range(0, 7));
      t.idx  = 5'($urandom_range(0, 31));
      t.cval = 1'($urandom_range(0, 1));
      t.last = 1'b0;
      return t;
   endfunction

   function automatic pf_token_type push_token();
      return make_token($urandom_range(0, 1) ? pfe_pkg::KIND_CONST : pfe_pkg::KIND_VAR);
   endfunction

   function automatic pf_token_type fixed_token(logic [1:0] kind, logic [2:0] code,
                                                logic [4:0] idx, logic cval, logic last);
      pf_token_type t;
      t.kind = kind;
      t.code = code;
      t.idx  = idx;
      t.cval = cval;
      t.last = last;
      return t;
   endfunction

   task automatic add_token(ref pf_token_type expr[$], input pf_token_type t);
      expr.insert(expr.size(), t);
   endtask

   task automatic send_token(input pf_token_type t);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_token_kind     <= t.kind;
      req_operator_code  <= t.code;
      req_variable_index <= t.idx;
      req_constant_value <= t.cval;
      req_last_token     <= t.last;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_expression(ref pf_token_type expr[$]);
      expr[expr.size()-1].last = 1'b1;
      foreach (expr[i]) send_token(expr[i]);
   endtask

   // hold the sender until every outstanding item has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_var_word(input logic [pfe_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= pfe_pkg::CSR_ADDR_VARS;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic build_well_formed(ref pf_token_type expr[$], input int leaves,
                                    input int max_fill);
      int fill;
      int pushed;
      int roll;
      fill   = 0;
      pushed = 0;
      while (pushed < leaves || fill > 1) begin
         roll = $urandom_range(0, 9);
         if (pushed < leaves && (fill < 2 || (roll < 5 && fill < max_fill))) begin
            add_token(expr, push_token());
            fill++;
            pushed++;
         end else if (roll == 9) begin
            add_token(expr, make_token(pfe_pkg::KIND_NEG));
         end else begin
            add_token(expr, make_token(pfe_pkg::KIND_BIN));
            fill--;
         end
      end
   endtask

   task automatic send_random_expression();
      pf_token_type expr[$];
      int           roll;
      int           n;
      roll = $urandom_range(0, 99);
      if (roll < 68) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
         build_well_formed(expr, n, $urandom_range(2, 12));
      end else if (roll < 78) begin
         // well-formed body with trailing junk
         build_well_formed(expr, $urandom_range(1, 8), 6);
         n = $urandom_range(1, 4);
         repeat (n) add_token(expr, make_token(2'($urandom_range(0, 3))));
      end else if (roll < 86) begin
         // operator on an empty stack, then a normal body
         add_token(expr, make_token($urandom_range(0, 1) ? pfe_pkg::KIND_NEG
                                                         : pfe_pkg::KIND_BIN));
         build_well_formed(expr, $urandom_range(1, 6), 4);
      end else if (roll < 89) begin
         // push past the top of the stack
         n = $urandom_range(pfe_pkg::STACK_DEPTH_DEF + 1, pfe_pkg::STACK_DEPTH_DEF + 3);
         repeat (n) add_token(expr, push_token());
         repeat ($urandom_range(0, 3)) add_token(expr, make_token(pfe_pkg::KIND_BIN));
      end else if (roll < 91) begin
         // fill the stack exactly, then fold it down
         repeat (pfe_pkg::STACK_DEPTH_DEF) add_token(expr, push_token());
         repeat (pfe_pkg::STACK_DEPTH_DEF - 1) add_token(expr, make_token(pfe_pkg::KIND_BIN));
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) add_token(expr, make_token(2'($urandom_range(0, 3))));
      end
      send_expression(expr);
   endtask

   // result side: a random stall before each item, with stall-free stretches
   initial begin
      int  stall;
      bit  rsp_burst;
      rsp_burst = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("[postfix_boolean_evaluator_unit] ERROR");
      $finish;
   end

   initial begin
      pf_token_type                   expr[$];
      logic [pfe_pkg::CSR_DATA_W-1:0] word;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bit 0 set, bit 31 clear
      write_var_word(32'h0F0F_0001);
      add_token(expr, fixed_token(pfe_pkg::KIND_VAR, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b1));
      add_token(expr, fixed_token(pfe_pkg::KIND_VAR, pfe_pkg::OP_AND, 5'd31, 1'b1, 1'b1));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_VAR, pfe_pkg::OP_AND, 5'd8, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_OR, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_NEG, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_VAR, pfe_pkg::OP_AND, 5'd4, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_NIMPT, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_TIMPN, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_VAR, pfe_pkg::OP_AND, 5'd16, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_EQV, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b0));
      // unused operator code folds to zero
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, OP_UNUSED, 5'd0, 1'b0, 1'b1));
      // negation on an empty stack
      add_token(expr, fixed_token(pfe_pkg::KIND_NEG, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b1));
      // binary with a single entry
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_BIN, pfe_pkg::OP_OR, 5'd0, 1'b0, 1'b1));
      // first error wins over the later depth problem
      add_token(expr, fixed_token(pfe_pkg::KIND_NEG, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b1));
      // two entries left at the end
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b0, 1'b0));
      add_token(expr, fixed_token(pfe_pkg::KIND_CONST, pfe_pkg::OP_AND, 5'd0, 1'b1, 1'b1));
      foreach (expr[i]) send_token(expr[i]);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         case (phase)
            0:       word = '0;
            1:       word = '1;
            4:       word = 32'hAAAA_AAAA;
            default: word = $urandom();
         endcase
         write_var_word(word);
         while (items_sent < (phase + 1) * ITEM_TOTAL / PHASE_COUNT) begin
            req_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 24) == 0) wait_drained();
            send_random_expression();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_results == 0)
         $display("[postfix_boolean_evaluator_unit] OK");
      else
         $display("[postfix_boolean_evaluator_unit] ERROR");
      $finish;
   end

endmodule
